FILE: rtl/core/txcon_pkg.sv
// ----------------------------------------------------------------------------
// txcon_pkg
// Shared types, sizes and character codes for the text console engine.
// ----------------------------------------------------------------------------
package txcon_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int LIN_W   = 11;
    localparam int CELL_W  = 16;
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int CIDX_W  = 11;

    localparam int IN_W    = OP_W + CHAR_W + CIDX_W;
    localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = ROW_W + COL_W + LIN_W + CELL_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ENQ   = 8'h05;
    localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_HT    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        PK_IGNORE,
        PK_BS,
        PK_LF,
        PK_CR,
        PK_DEL,
        PK_PRINT
    } put_kind_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD_DATA,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_BS_RD,
        ST_BS_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   opcode;
        logic [CHAR_W-1:0] char_code;
        logic [CIDX_W-1:0] cell_index;
    } req_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [LIN_W-1:0]  cursor_linear;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } result_t;

    function automatic put_kind_t char_kind(input logic [CHAR_W-1:0] ch);
        put_kind_t k;
        case (ch)
            CH_NUL, CH_ENQ, CH_BEL, CH_HT, CH_VT, CH_FF: k = PK_IGNORE;
            CH_BS:   k = PK_BS;
            CH_LF:   k = PK_LF;
            CH_CR:   k = PK_CR;
            CH_DEL:  k = PK_DEL;
            default: k = PK_PRINT;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/core/txcon_ram.sv
// ----------------------------------------------------------------------------
// txcon_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module txcon_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/txcon_ctrl.sv
// ----------------------------------------------------------------------------
// txcon_ctrl
// Sequencer for the console: cursor, screen store access, scroll, clear and
// backspace search, all through one address/compare unit and one RAM port pair.
// ----------------------------------------------------------------------------
module txcon_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  txcon_pkg::req_t                     req,
    input  logic [txcon_pkg::CELL_W-1:0]        blank_cell,
    input  logic                                out_free,
    output logic                                in_ready,
    output logic                                out_load,
    output txcon_pkg::result_t                  result
);

    localparam logic [txcon_pkg::ADDR_W-1:0] LAST_CELL =
        txcon_pkg::ADDR_W'(txcon_pkg::CELLS - 1);
    localparam logic [txcon_pkg::ADDR_W-1:0] SCROLL_LAST =
        txcon_pkg::ADDR_W'(txcon_pkg::CELLS - txcon_pkg::COLUMNS - 1);
    localparam logic [txcon_pkg::ADDR_W-1:0] BOTTOM_BASE =
        txcon_pkg::ADDR_W'(txcon_pkg::CELLS - txcon_pkg::COLUMNS);
    localparam logic [txcon_pkg::COL_W-1:0] COL_LAST =
        txcon_pkg::COL_W'(txcon_pkg::COLUMNS - 1);
    localparam logic [txcon_pkg::COL_W-1:0] COL_SCAN0 =
        txcon_pkg::COL_W'(txcon_pkg::COLUMNS - 2);
    localparam logic [txcon_pkg::ROW_W-1:0] ROW_LAST =
        txcon_pkg::ROW_W'(txcon_pkg::ROWS - 1);

    txcon_pkg::state_t                 state_reg, state_next;
    logic [txcon_pkg::ROW_W-1:0]       row_reg, row_next;
    logic [txcon_pkg::COL_W-1:0]       col_reg, col_next;
    logic [txcon_pkg::ADDR_W-1:0]      ptr_reg, ptr_next;
    logic [txcon_pkg::CHAR_W-1:0]      rmw_char_reg, rmw_char_next;
    logic                              rmw_adv_reg, rmw_adv_next;
    logic [txcon_pkg::CELL_W-1:0]      cell_reg, cell_next;

    logic                              ram_we;
    logic [txcon_pkg::ADDR_W-1:0]      ram_wr_addr;
    logic [txcon_pkg::CELL_W-1:0]      ram_wr_data;
    logic [txcon_pkg::ADDR_W-1:0]      ram_rd_addr;
    logic [txcon_pkg::CELL_W-1:0]      ram_rd_data;

    logic [txcon_pkg::ADDR_W-1:0]      here;
    logic                              at_bottom;
    logic                              in_range;
    logic                              rd_hit;
    txcon_pkg::put_kind_t              kind;

    assign here      = txcon_pkg::ADDR_W'(row_reg * txcon_pkg::COLUMNS)
                     + txcon_pkg::ADDR_W'(col_reg);
    assign at_bottom = (row_reg == ROW_LAST);
    assign in_range  = (32'(req.cell_index) < 32'(txcon_pkg::CELLS));
    assign rd_hit    = (ram_rd_data[txcon_pkg::CHAR_W-1:0] != txcon_pkg::CH_SPACE);
    assign kind      = txcon_pkg::char_kind(req.char_code);

    txcon_ram #(
        .WIDTH (txcon_pkg::CELL_W),
        .DEPTH (txcon_pkg::CELLS)
    ) u_screen (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            txcon_pkg::ST_INIT:
            begin
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = txcon_pkg::ST_IDLE;
                end
            end
            txcon_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.opcode)
                        txcon_pkg::OP_READ:
                            state_next = in_range ? txcon_pkg::ST_RD_DATA : txcon_pkg::ST_DONE;
                        txcon_pkg::OP_CLEAR:
                            state_next = txcon_pkg::ST_FILL;
                        txcon_pkg::OP_PUT:
                        begin
                            case (kind)
                                txcon_pkg::PK_BS:
                                begin
                                    if (col_reg != '0)
                                        state_next = txcon_pkg::ST_RMW_RD;
                                    else if (row_reg != '0)
                                        state_next = txcon_pkg::ST_BS_RD;
                                    else
                                        state_next = txcon_pkg::ST_DONE;
                                end
                                txcon_pkg::PK_LF:
                                    state_next = at_bottom ? txcon_pkg::ST_SCROLL_RD
                                                           : txcon_pkg::ST_DONE;
                                txcon_pkg::PK_DEL, txcon_pkg::PK_PRINT:
                                    state_next = txcon_pkg::ST_RMW_RD;
                                default:
                                    state_next = txcon_pkg::ST_DONE;
                            endcase
                        end
                        default:
                            state_next = txcon_pkg::ST_DONE;
                    endcase
                end
            end
            txcon_pkg::ST_RD_DATA:
                state_next = txcon_pkg::ST_DONE;
            txcon_pkg::ST_RMW_RD:
                state_next = txcon_pkg::ST_RMW_WR;
            txcon_pkg::ST_RMW_WR:
            begin
                if (rmw_adv_reg && (col_reg == COL_LAST) && at_bottom)
                    state_next = txcon_pkg::ST_SCROLL_RD;
                else
                    state_next = txcon_pkg::ST_DONE;
            end
            txcon_pkg::ST_BS_RD:
                state_next = txcon_pkg::ST_BS_CHK;
            txcon_pkg::ST_BS_CHK:
                state_next = rd_hit ? txcon_pkg::ST_DONE : txcon_pkg::ST_SCAN_RD;
            txcon_pkg::ST_SCAN_RD:
                state_next = txcon_pkg::ST_SCAN_CHK;
            txcon_pkg::ST_SCAN_CHK:
            begin
                if (rd_hit || (col_reg == '0))
                    state_next = txcon_pkg::ST_DONE;
                else
                    state_next = txcon_pkg::ST_SCAN_RD;
            end
            txcon_pkg::ST_SCROLL_RD:
                state_next = txcon_pkg::ST_SCROLL_WR;
            txcon_pkg::ST_SCROLL_WR:
            begin
                if (ptr_reg == SCROLL_LAST)
                    state_next = txcon_pkg::ST_FILL;
                else
                    state_next = txcon_pkg::ST_SCROLL_RD;
            end
            txcon_pkg::ST_FILL:
            begin
                if (ptr_reg == LAST_CELL)
                    state_next = txcon_pkg::ST_DONE;
            end
            txcon_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = txcon_pkg::ST_IDLE;
            end
            default:
                state_next = txcon_pkg::ST_IDLE;
        endcase
    end

    // outputs and RAM ports
    always_comb
    begin
        in_ready    = 1'b0;
        out_load    = 1'b0;
        ram_we      = 1'b0;
        ram_wr_addr = here;
        ram_wr_data = {ram_rd_data[txcon_pkg::CELL_W-1:txcon_pkg::CHAR_W], rmw_char_reg};
        ram_rd_addr = here;
        case (state_reg)
            txcon_pkg::ST_INIT:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = ptr_reg;
                ram_wr_data = txcon_pkg::RESET_CELL;
            end
            txcon_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                ram_rd_addr = in_range ? txcon_pkg::ADDR_W'(req.cell_index) : '0;
            end
            txcon_pkg::ST_RMW_WR:
                ram_we = 1'b1;
            txcon_pkg::ST_BS_CHK:
            begin
                ram_we      = rd_hit;
                ram_wr_data = {ram_rd_data[txcon_pkg::CELL_W-1:txcon_pkg::CHAR_W],
                               txcon_pkg::CH_SPACE};
            end
            txcon_pkg::ST_SCROLL_RD:
                ram_rd_addr = ptr_reg + txcon_pkg::ADDR_W'(txcon_pkg::COLUMNS);
            txcon_pkg::ST_SCROLL_WR:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = ptr_reg;
                ram_wr_data = ram_rd_data;
            end
            txcon_pkg::ST_FILL:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = ptr_reg;
                ram_wr_data = blank_cell;
            end
            txcon_pkg::ST_DONE:
                out_load = out_free;
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // cursor and working registers
    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        ptr_next      = ptr_reg;
        rmw_char_next = rmw_char_reg;
        rmw_adv_next  = rmw_adv_reg;
        cell_next     = cell_reg;
        case (state_reg)
            txcon_pkg::ST_INIT:
                ptr_next = ptr_reg + 1'b1;
            txcon_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    cell_next = '0;
                    case (req.opcode)
                        txcon_pkg::OP_CLEAR:
                        begin
                            row_next = '0;
                            col_next = '0;
                            ptr_next = '0;
                        end
                        txcon_pkg::OP_PUT:
                        begin
                            case (kind)
                                txcon_pkg::PK_CR:
                                    col_next = '0;
                                txcon_pkg::PK_LF:
                                begin
                                    col_next = '0;
                                    if (at_bottom)
                                        ptr_next = '0;
                                    else
                                        row_next = row_reg + 1'b1;
                                end
                                txcon_pkg::PK_BS:
                                begin
                                    rmw_char_next = txcon_pkg::CH_SPACE;
                                    rmw_adv_next  = 1'b0;
                                    if (col_reg != '0)
                                    begin
                                        col_next = col_reg - 1'b1;
                                    end
                                    else if (row_reg != '0)
                                    begin
                                        row_next = row_reg - 1'b1;
                                        col_next = COL_LAST;
                                    end
                                end
                                txcon_pkg::PK_DEL:
                                begin
                                    rmw_char_next = txcon_pkg::CH_SPACE;
                                    rmw_adv_next  = 1'b0;
                                end
                                txcon_pkg::PK_PRINT:
                                begin
                                    rmw_char_next = req.char_code;
                                    rmw_adv_next  = 1'b1;
                                end
                                default:
                                    rmw_adv_next = rmw_adv_reg;
                            endcase
                        end
                        default:
                            cell_next = '0;
                    endcase
                end
            end
            txcon_pkg::ST_RD_DATA:
                cell_next = ram_rd_data;
            txcon_pkg::ST_RMW_WR:
            begin
                if (rmw_adv_reg)
                begin
                    if (col_reg == COL_LAST)
                    begin
                        col_next = '0;
                        if (at_bottom)
                            ptr_next = '0;
                        else
                            row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            txcon_pkg::ST_BS_CHK:
            begin
                if (!rd_hit)
                    col_next = COL_SCAN0;
            end
            txcon_pkg::ST_SCAN_CHK:
            begin
                if (rd_hit)
                    col_next = col_reg + 1'b1;
                else if (col_reg != '0)
                    col_next = col_reg - 1'b1;
            end
            txcon_pkg::ST_SCROLL_WR:
                ptr_next = (ptr_reg == SCROLL_LAST) ? BOTTOM_BASE : ptr_reg + 1'b1;
            txcon_pkg::ST_FILL:
                ptr_next = ptr_reg + 1'b1;
            default:
                ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= txcon_pkg::ST_INIT;
            row_reg   <= '0;
            col_reg   <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rmw_char_reg <= rmw_char_next;
        rmw_adv_reg  <= rmw_adv_next;
        cell_reg     <= cell_next;
    end

    assign result.cursor_row    = row_reg;
    assign result.cursor_col    = col_reg;
    assign result.cursor_linear = txcon_pkg::LIN_W'(here);
    assign result.cell_value    = cell_reg;

endmodule

FILE: rtl/core/text_console_char_engine.sv
// ----------------------------------------------------------------------------
// text_console_char_engine
// Character-cell text console with an 80x25 screen store and a cursor.
// ----------------------------------------------------------------------------
// Commands enter on the s_axis channel, one beat per command; every command
// returns exactly one beat on m_axis carrying the cursor after the command
// and, for a cell read, the cell word.
// cfg_we/cfg_wdata load the blank cell word used by clear and scroll.
// Commands that only move the cursor, and the unused opcode, go straight to
// the result. A cell read past the screen end returns a zero cell word
// without a RAM read. Printable bytes, DEL and simple BS read, then write
// back, the cell at the cursor. BS onto the previous line checks its last
// cell, then searches it backwards. Clear fills every cell with the blank
// word; a line feed on the last row, or a printable byte wrapping off it,
// first copies each row up by one, then fills the bottom row.
// s_axis_tready is low while a command is in work; commands are one at a time.
// After reset the screen is swept to 0x0720, one cell a cycle, with
// s_axis_tready low. The result sits in an output register; a stalled
// receiver holds it, and the next command is accepted meanwhile but its
// result waits until that register is free.
// ----------------------------------------------------------------------------
module text_console_char_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // opcode, char_code, cell_index
    input  logic [txcon_pkg::IN_BYTES_W-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // cursor_row, cursor_col, cursor_linear, cell_value
    output logic [txcon_pkg::OUT_BYTES_W-1:0]   m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [txcon_pkg::CELL_W-1:0]        cfg_wdata
);

    txcon_pkg::req_t                   req;
    txcon_pkg::result_t                result;
    logic                              in_ready;
    logic                              out_load;
    logic                              out_free;
    logic [txcon_pkg::CELL_W-1:0]      blank_cell_reg;
    logic                              m_valid_reg;
    logic [txcon_pkg::OUT_W-1:0]       m_data_reg;

    assign req.valid      = s_axis_tvalid && in_ready;
    assign req.opcode     = s_axis_tdata[txcon_pkg::OP_W-1:0];
    assign req.char_code  = s_axis_tdata[txcon_pkg::OP_W +: txcon_pkg::CHAR_W];
    assign req.cell_index = s_axis_tdata[txcon_pkg::OP_W + txcon_pkg::CHAR_W +: txcon_pkg::CIDX_W];

    assign out_free = !m_valid_reg || m_axis_tready;

    txcon_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .blank_cell (blank_cell_reg),
        .out_free   (out_free),
        .in_ready   (in_ready),
        .out_load   (out_load),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_cell_reg <= txcon_pkg::RESET_CELL;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                blank_cell_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= result;
        end
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = txcon_pkg::OUT_BYTES_W'(m_data_reg);

endmodule

FILE: rtl/core/txcon_checker.sv
// ----------------------------------------------------------------------------
// txcon_checker
// Port-level checks for the text console engine, bound to the top level.
// ----------------------------------------------------------------------------
module txcon_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [txcon_pkg::OUT_BYTES_W-1:0]   m_axis_tdata
);

    localparam int COL_LO = txcon_pkg::ROW_W;
    localparam int LIN_LO = txcon_pkg::ROW_W + txcon_pkg::COL_W;

    logic [txcon_pkg::ROW_W-1:0] out_row;
    logic [txcon_pkg::COL_W-1:0] out_col;
    logic [txcon_pkg::LIN_W-1:0] out_lin;
    logic                        in_beat;

    assign out_row = m_axis_tdata[txcon_pkg::ROW_W-1:0];
    assign out_col = m_axis_tdata[COL_LO +: txcon_pkg::COL_W];
    assign out_lin = m_axis_tdata[LIN_LO +: txcon_pkg::LIN_W];
    assign in_beat = s_axis_tvalid && s_axis_tready;

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_axis_tready)
        else $error("input accepted while a command is in work");

    a_cursor_inside: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(out_col) < 32'(txcon_pkg::COLUMNS))
                       && (32'(out_row) < 32'(txcon_pkg::ROWS)))
        else $error("cursor outside the screen");

    a_linear_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> 32'(out_lin) ==
            32'(out_row) * 32'(txcon_pkg::COLUMNS) + 32'(out_col))
        else $error("linear cursor disagrees with row and column");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped under stall");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed under stall");

endmodule

bind text_console_char_engine txcon_checker u_txcon_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/tb_text_console_char_engine.sv
// ----------------------------------------------------------------------------
// tb_text_console_char_engine
// Self-checking bench for the character-cell text console engine.
// ----------------------------------------------------------------------------
// A short directed table comes first. It covers cell reads at and past the
// screen end, the unused opcode, and backspace at the top left. It also puts
// printable, high and ignored bytes, then DEL, CR, LF, backspace onto the
// previous line with and without a hit, and clear. Four random segments
// follow, each with its own blank cell word (zero, all ones, a space
// character word, random). Their traffic is mostly text with line feeds and
// backspaces, which fills the screen and keeps it scrolling, plus reads near
// the cursor and some noise. A local screen image predicts the cursor and the
// cell word of every command. Result beats are checked in order.
// ----------------------------------------------------------------------------
module tb_text_console_char_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import txcon_pkg::*;

    localparam int STALL_LIMIT  = 20000;
    localparam int SEGMENTS     = 4;
    localparam int SEGMENT_CMDS = 306;
    localparam int SHOWN_ERRORS = 40;

    typedef struct {
        opcode_t            op;
        logic [CHAR_W-1:0]  ch;
        logic [CIDX_W-1:0]  idx;
        bit                 typed;
        bit                 idle_code;
        result_t            want;
    } console_cmd_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_BYTES_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CELL_W-1:0]      cfg_wdata = '0;

    logic [CELL_W-1:0] screen_mem [0:CELLS-1];
    logic [CELL_W-1:0] blank_word;
    int                crow;
    int                ccol;

    result_t      pending_views [$];
    console_cmd_t batch [$];

    int src_idle_pct  = 9;
    int sink_idle_pct = 74;
    int err_count     = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int scroll_count  = 0;
    int search_count  = 0;
    int stall_cycles  = 0;

    text_console_char_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        if (err_count < SHOWN_ERRORS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void space_out(input int addr);
        screen_mem[addr][7:0] = CH_SPACE;
    endfunction

    function automatic void advance_line();
        ccol = 0;
        if (crow + 1 < ROWS)
            crow++;
        else
        begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen_mem[i] = screen_mem[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen_mem[i] = blank_word;
            scroll_count++;
        end
    endfunction

    function automatic result_t console_step(input console_cmd_t c);
        result_t r;
        int      base;
        bit      hit;
        r = '0;
        case (c.op)
            OP_PUT:
                case (c.ch)
                    CH_NUL, CH_ENQ, CH_BEL, CH_HT, CH_VT, CH_FF: ;
                    CH_BS:
                        if (ccol > 0)
                        begin
                            ccol--;
                            space_out(crow * COLUMNS + ccol);
                        end
                        else if (crow > 0)
                        begin
                            crow--;
                            base = crow * COLUMNS;
                            ccol = COLUMNS - 1;
                            if (screen_mem[base + ccol][7:0] != CH_SPACE)
                                space_out(base + ccol);
                            else
                            begin
                                ccol = 0;
                                hit = 1'b0;
                                for (int x = COLUMNS - 1; x > 0; x--)
                                    if (!hit && screen_mem[base + x - 1][7:0] != CH_SPACE)
                                    begin
                                        ccol = x;
                                        hit = 1'b1;
                                    end
                                search_count++;
                            end
                        end
                    CH_LF:  advance_line();
                    CH_CR:  ccol = 0;
                    CH_DEL: space_out(crow * COLUMNS + ccol);
                    default:
                    begin
                        screen_mem[crow * COLUMNS + ccol][7:0] = c.ch;
                        ccol++;
                        if (ccol >= COLUMNS)
                            advance_line();
                    end
                endcase
            OP_READ:
                if (c.idx < CELLS)
                    r.cell_value = screen_mem[c.idx];
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_mem[i] = blank_word;
                crow = 0;
                ccol = 0;
            end
            default: ;
        endcase
        r.cursor_row    = ROW_W'(crow);
        r.cursor_col    = COL_W'(ccol);
        r.cursor_linear = LIN_W'(crow * COLUMNS + ccol);
        return r;
    endfunction

    function automatic console_cmd_t make_cmd(input opcode_t op, input logic [CHAR_W-1:0] ch,
                                              input logic [CIDX_W-1:0] idx);
        console_cmd_t c;
        c.op        = op;
        c.ch        = ch;
        c.idx       = idx;
        c.typed     = 1'b0;
        c.idle_code = 1'b0;
        c.want      = '0;
        return c;
    endfunction

    function automatic console_cmd_t make_checked(input opcode_t op,
                                                  input logic [CHAR_W-1:0] ch,
                                                  input logic [CIDX_W-1:0] idx,
                                                  input int row, input int col, input int lin,
                                                  input logic [CELL_W-1:0] cell_word);
        console_cmd_t c;
        c = make_cmd(op, ch, idx);
        c.typed              = 1'b1;
        c.want.cursor_row    = ROW_W'(row);
        c.want.cursor_col    = COL_W'(col);
        c.want.cursor_linear = LIN_W'(lin);
        c.want.cell_value    = cell_word;
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] text_byte();
        logic [CHAR_W-1:0] b;
        int                r;
        r = $urandom_range(0, 9);
        if (r < 8)
            b = CHAR_W'($urandom_range(8'h21, 8'h7E));
        else if (r == 8)
            b = CH_SPACE;
        else
            b = CHAR_W'($urandom_range(128, 255));
        return b;
    endfunction

    task automatic send_cmd(input console_cmd_t c);
        result_t want;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = '0;
        s_axis_tdata[IN_W-1:0] = {c.idx, c.ch, c.op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = console_step(c);
        pending_views.push_back(c.typed ? c.want : want);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic load_blank(input logic [CELL_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        blank_word = value;
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (pending_views.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Mostly text with line feeds so the screen fills and keeps scrolling.
    task automatic queue_burst();
        console_cmd_t      c;
        int                pick;
        int                len;
        int                r;
        logic [OP_W-1:0]   op_bits;
        logic [CHAR_W-1:0] ch;
        logic [CIDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 38)
        begin
            len = $urandom_range(1, 8);
            repeat (len)
                batch.push_back(make_cmd(OP_PUT, text_byte(), CIDX_W'($urandom_range(0, 2047))));
            batch.push_back(make_cmd(OP_PUT, CH_SPACE, CIDX_W'($urandom_range(0, 2047))));
        end
        else if (pick < 39)
        begin
            len = $urandom_range(60, 100);
            repeat (len)
                batch.push_back(make_cmd(OP_PUT, text_byte(), CIDX_W'($urandom_range(0, 2047))));
        end
        else if (pick < 59)
            batch.push_back(make_cmd(OP_PUT, CH_LF, CIDX_W'($urandom_range(0, 2047))));
        else if (pick < 67)
        begin
            batch.push_back(make_cmd(OP_PUT, CH_LF, CIDX_W'($urandom_range(0, 2047))));
            len = $urandom_range(1, 3);
            repeat (len)
                batch.push_back(make_cmd(OP_PUT, CH_BS, CIDX_W'($urandom_range(0, 2047))));
        end
        else if (pick < 70)
            batch.push_back(make_cmd(OP_PUT, CH_CR, CIDX_W'($urandom_range(0, 2047))));
        else if (pick < 76)
        begin
            len = $urandom_range(1, 4);
            repeat (len)
                batch.push_back(make_cmd(OP_PUT, CH_BS, CIDX_W'($urandom_range(0, 2047))));
        end
        else if (pick < 78)
            batch.push_back(make_cmd(OP_PUT, CH_DEL, CIDX_W'($urandom_range(0, 2047))));
        else if (pick < 80)
        begin
            case ($urandom_range(0, 5))
                0:       ch = CH_NUL;
                1:       ch = CH_ENQ;
                2:       ch = CH_BEL;
                3:       ch = CH_HT;
                4:       ch = CH_VT;
                default: ch = CH_FF;
            endcase
            c = make_cmd(OP_PUT, ch, CIDX_W'($urandom_range(0, 2047)));
            c.idle_code = 1'b1;
            batch.push_back(c);
        end
        else if (pick < 90)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                idx = CIDX_W'(crow * COLUMNS + int'($urandom_range(0, COLUMNS - 1)));
            else if (r < 9)
                idx = CIDX_W'($urandom_range(0, CELLS - 1));
            else
                idx = CIDX_W'($urandom_range(CELLS, 2047));
            batch.push_back(make_cmd(OP_READ, CHAR_W'($urandom_range(0, 255)), idx));
        end
        else if (pick < 91)
        begin
            if ($urandom_range(0, 3) == 0)
                batch.push_back(make_cmd(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                                         CIDX_W'($urandom_range(0, 2047))));
            else
                batch.push_back(make_cmd(OP_NONE, CHAR_W'($urandom_range(0, 255)),
                                         CIDX_W'($urandom_range(0, 2047))));
        end
        else
        begin
            // Keep clears rare: each one throws away a full screen.
            op_bits = OP_W'($urandom_range(0, 3));
            if (op_bits == OP_CLEAR)
                op_bits = OP_NONE;
            batch.push_back(make_cmd(opcode_t'(op_bits), CHAR_W'($urandom_range(0, 255)),
                                     CIDX_W'($urandom_range(0, 2047))));
        end
    endtask

    always @(negedge clk)
        m_axis_tready = ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("no beat moved for %0d cycles", STALL_LIMIT);
                $display("tb_text_console_char_engine: done, errors");
                $finish;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[OUT_W-1:0]);
                if (pending_views.size() == 0)
                    flag_error($sformatf("result beat %h with nothing pending", got));
                else
                begin
                    want = pending_views.pop_front();
                    if (got.cursor_row !== want.cursor_row)
                        flag_error($sformatf("result %0d cursor_row %0d, want %0d",
                                             checked_count, got.cursor_row, want.cursor_row));
                    if (got.cursor_col !== want.cursor_col)
                        flag_error($sformatf("result %0d cursor_col %0d, want %0d",
                                             checked_count, got.cursor_col, want.cursor_col));
                    if (got.cursor_linear !== want.cursor_linear)
                        flag_error($sformatf("result %0d cursor_linear %0d, want %0d",
                                             checked_count, got.cursor_linear,
                                             want.cursor_linear));
                    if (got.cell_value !== want.cell_value)
                        flag_error($sformatf("result %0d cell_value %h, want %h",
                                             checked_count, got.cell_value, want.cell_value));
                    checked_count++;
                end
            end
        end
    end

    initial
    begin
        console_cmd_t      plan [$];
        console_cmd_t      c;
        logic [CELL_W-1:0] seg_blank [SEGMENTS];
        int                count;

        for (int i = 0; i < CELLS; i++)
            screen_mem[i] = RESET_CELL;
        blank_word = RESET_CELL;
        crow = 0;
        ccol = 0;

        plan.push_back(make_checked(OP_READ,  8'h00, 11'd0,    0, 0, 0, RESET_CELL));
        plan.push_back(make_checked(OP_READ,  8'hFF, 11'd1999, 0, 0, 0, RESET_CELL));
        plan.push_back(make_checked(OP_READ,  8'h00, 11'd2000, 0, 0, 0, '0));
        plan.push_back(make_checked(OP_READ,  8'h00, 11'd2047, 0, 0, 0, '0));
        plan.push_back(make_checked(OP_NONE,  8'hFF, 11'd2047, 0, 0, 0, '0));
        plan.push_back(make_checked(OP_PUT,   CH_BS, 11'd0,    0, 0, 0, '0));
        plan.push_back(make_checked(OP_PUT,   8'h41, 11'd0,    0, 1, 1, '0));
        plan.push_back(make_checked(OP_PUT,   8'hFF, 11'd0,    0, 2, 2, '0));
        plan.push_back(make_checked(OP_PUT,   8'h80, 11'd0,    0, 3, 3, '0));
        plan.push_back(make_checked(OP_PUT,   CH_NUL, 11'd0,   0, 3, 3, '0));
        plan.push_back(make_checked(OP_PUT,   CH_ENQ, 11'd0,   0, 3, 3, '0));
        plan.push_back(make_checked(OP_PUT,   CH_BEL, 11'd0,   0, 3, 3, '0));
        plan.push_back(make_checked(OP_PUT,   CH_HT, 11'd0,    0, 3, 3, '0));
        plan.push_back(make_checked(OP_PUT,   CH_VT, 11'd0,    0, 3, 3, '0));
        plan.push_back(make_checked(OP_PUT,   CH_FF, 11'd0,    0, 3, 3, '0));
        plan.push_back(make_checked(OP_PUT,   8'h01, 11'd0,    0, 4, 4, '0));
        plan.push_back(make_checked(OP_PUT,   CH_DEL, 11'd0,   0, 4, 4, '0));
        plan.push_back(make_checked(OP_PUT,   CH_BS, 11'd0,    0, 3, 3, '0));
        plan.push_back(make_checked(OP_PUT,   CH_CR, 11'd0,    0, 0, 0, '0));
        plan.push_back(make_checked(OP_PUT,   CH_LF, 11'd0,    1, 0, 80, '0));
        plan.push_back(make_cmd(OP_PUT,  CH_BS, 11'd0));
        plan.push_back(make_cmd(OP_READ, 8'h00, 11'd0));
        plan.push_back(make_cmd(OP_READ, 8'h00, 11'd2));
        plan.push_back(make_checked(OP_CLEAR, 8'h00, 11'd0,    0, 0, 0, '0));
        plan.push_back(make_checked(OP_PUT,   CH_LF, 11'd0,    1, 0, 80, '0));
        plan.push_back(make_checked(OP_PUT,   CH_BS, 11'd0,    0, 0, 0, '0));
        plan.push_back(make_checked(OP_READ,  8'h00, 11'd79,   0, 0, 0, RESET_CELL));

        seg_blank[0] = 16'h0000;
        seg_blank[1] = 16'hFFFF;
        seg_blank[2] = 16'h1F20;
        seg_blank[3] = CELL_W'($urandom_range(0, 65535));

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
            send_cmd(plan[i]);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_results();
            load_blank(seg_blank[seg]);
            case (seg)
                0:
                begin
                    src_idle_pct  = 9;
                    sink_idle_pct = 74;
                end
                1:
                begin
                    src_idle_pct  = 74;
                    sink_idle_pct = 9;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            count = 0;
            while (count < SEGMENT_CMDS)
            begin
                queue_burst();
                while (batch.size() != 0)
                begin
                    c = batch.pop_front();
                    send_cmd(c);
                    if (!c.idle_code)
                        count++;
                end
            end
        end

        drain_results();
        repeat (20) @(negedge clk);
        if (pending_views.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_views.size()));

        $display("sent %0d commands, checked %0d result beats, %0d mismatches",
                 sent_count, checked_count, err_count);
        $display("saw %0d scrolls and %0d previous-line searches, blank words 0000 ffff 1f20 %h",
                 scroll_count, search_count, seg_blank[3]);
        if (err_count == 0)
            $display("tb_text_console_char_engine: done, clean");
        else
            $display("tb_text_console_char_engine: done, errors");
        $finish;
    end

endmodule
